// File: rtl/etrr_pkg.sv
package etrr_pkg;

    // Command codes.
    localparam logic [2:0] CMD_CREATE    = 3'd0;
    localparam logic [2:0] CMD_REMOVE    = 3'd1;
    localparam logic [2:0] CMD_FIND_PORT = 3'd2;
    localparam logic [2:0] CMD_GET_INDEX = 3'd3;
    localparam logic [2:0] CMD_FIND_HEAP = 3'd4;
    localparam logic [2:0] CMD_MARK      = 3'd5;
    localparam logic [2:0] CMD_NEXT      = 3'd6;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_PORT_USED  = 3'd2;
    localparam logic [2:0] ST_NO_PROFILE = 3'd3;
    localparam logic [2:0] ST_NEEDS_INST = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [2:0] ST_NONE_PEND  = 3'd6;

    // Compare modes of the shared match unit.
    localparam logic [1:0] MODE_PORT = 2'd0;
    localparam logic [1:0] MODE_HEAP = 2'd1;
    localparam logic [1:0] MODE_PEND = 2'd2;
    localparam logic [1:0] MODE_ANY  = 2'd3;

    // One table entry as stored in the entry memory.
    typedef struct packed {
        logic [7:0]  port;
        logic [15:0] profile;
        logic [7:0]  heap;
        logic        is_virtual;
        logic        pending;
    } entry_t;

endpackage

// File: rtl/etrr_ram.sv
module etrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/etrr_match.sv
module etrr_match
    import etrr_pkg::*;
(
    input  logic [1:0] mode,
    input  entry_t     entry,
    input  logic [7:0] key_port,
    input  logic [7:0] key_heap,
    output logic       hit
);

    // Single compare unit shared by every search the sequencer runs.
    always_comb
    begin
        case (mode)
            MODE_PORT: hit = (entry.port == key_port);
            MODE_HEAP: hit = (entry.heap == key_heap);
            MODE_PEND: hit = entry.pending;
            default:   hit = 1'b1;
        endcase
    end

endmodule

// File: rtl/endpoint_table_round_robin.sv
// Endpoint table with round-robin update scheduling.
//
// Command channel: drive cmd and its operand ports with start high; a beat
// is taken at a rising edge where start is high and busy is low. busy stays
// high while the command runs. The result beat appears on status, the hit_*
// ports, call_native_update and entry_total for exactly one cycle, marked by
// done; the receiver cannot stall, so it must take the beat in that cycle.
// Entries live in one memory with a single registered read port, and every
// search walks that port one entry per cycle through a shared compare unit.
// Commands rejected up front report without a scan; searches (create, find,
// mark, next pending) walk the live entries, get by index reads one entry,
// and remove then shifts the later entries down through the same read port.
// A new command can be taken in the cycle that shows the result beat.
// Reset clears the entry count and the round-robin pointer; the memory is
// not cleared, since only slots below the entry count are ever used.
module endpoint_table_round_robin
    import etrr_pkg::*;
#(
    parameter int MAX_ENDPOINTS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  port,
    input  logic [15:0] profile_key,
    input  logic [7:0]  heap_id,
    input  logic [3:0]  slot,
    input  logic        profile_found,
    input  logic        profile_virtual,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  hit_slot,
    output logic [7:0]  hit_port,
    output logic [15:0] hit_profile,
    output logic [7:0]  hit_heap,
    output logic        hit_virtual,
    output logic        call_native_update,
    output logic [3:0]  entry_total
);

    localparam int IW   = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
    localparam int CW   = $clog2(MAX_ENDPOINTS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    cmd_q_reg, cmd_q_next;
    logic [7:0]    port_q_reg, port_q_next;
    logic [15:0]   prof_q_reg, prof_q_next;
    logic [7:0]    heap_q_reg, heap_q_next;
    logic          found_q_reg, found_q_next;
    logic          virt_q_reg, virt_q_next;
    logic [1:0]    mode_reg, mode_next;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] scan_left_reg, scan_left_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic [CW-1:0] used_count_reg, used_count_next;
    logic [IW-1:0] last_served_reg, last_served_next;
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [3:0]    hit_slot_reg, hit_slot_next;
    logic [7:0]    hit_port_reg, hit_port_next;
    logic [15:0]   hit_profile_reg, hit_profile_next;
    logic [7:0]    hit_heap_reg, hit_heap_next;
    logic          hit_virtual_reg, hit_virtual_next;
    logic          call_native_reg, call_native_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_entry;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t        rd_entry;
    logic          match;
    logic [IW-1:0] idx_inc;
    logic [IW-1:0] last_clamp;
    logic [IW-1:0] rr_start;

    // Entry memory and the shared compare unit.
    etrr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENDPOINTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);

    etrr_match u_match (
        .mode     (mode_reg),
        .entry    (rd_entry),
        .key_port (port_q_reg),
        .key_heap (heap_q_reg),
        .hit      (match)
    );

    // Read address steps through the table, wrapping at the entry count.
    assign idx_inc = ((CW'(scan_idx_reg) + CW'(1)) == used_count_reg) ?
                     '0 : scan_idx_reg + IW'(1);

    // A stale round-robin pointer is pulled back to the last live slot.
    assign last_clamp = (CMPW'(last_served_reg) >= CMPW'(used_count_reg)) ?
                        IW'(used_count_reg - CW'(1)) : last_served_reg;
    assign rr_start   = ((CW'(last_clamp) + CW'(1)) == used_count_reg) ?
                        '0 : last_clamp + IW'(1);

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        cmd_q_next       = cmd_q_reg;
        port_q_next      = port_q_reg;
        prof_q_next      = prof_q_reg;
        heap_q_next      = heap_q_reg;
        found_q_next     = found_q_reg;
        virt_q_next      = virt_q_reg;
        mode_next        = mode_reg;
        scan_idx_next    = scan_idx_reg;
        scan_left_next   = scan_left_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        used_count_next  = used_count_reg;
        last_served_next = last_served_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        hit_slot_next    = hit_slot_reg;
        hit_port_next    = hit_port_reg;
        hit_profile_next = hit_profile_reg;
        hit_heap_next    = hit_heap_reg;
        hit_virtual_next = hit_virtual_reg;
        call_native_next = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = chk_idx_reg;
        wr_entry         = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_q_next       = cmd;
                    port_q_next      = port;
                    prof_q_next      = profile_key;
                    heap_q_next      = heap_id;
                    found_q_next     = profile_found;
                    virt_q_next      = profile_virtual;
                    scan_idx_next    = '0;
                    scan_left_next   = used_count_reg;
                    mode_next        = MODE_PORT;
                    state_next       = S_SCAN;
                    hit_slot_next    = '0;
                    hit_port_next    = '0;
                    hit_profile_next = '0;
                    hit_heap_next    = '0;
                    hit_virtual_next = 1'b0;
                    status_next      = ST_OK;
                    unique case (cmd)
                        CMD_CREATE:
                        begin
                            if (used_count_reg == CW'(MAX_ENDPOINTS))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end
                        CMD_REMOVE, CMD_FIND_PORT, CMD_MARK:
                        begin
                            mode_next = MODE_PORT;
                        end
                        CMD_GET_INDEX:
                        begin
                            if (CMPW'(slot) >= CMPW'(used_count_reg))
                            begin
                                status_next = ST_NOT_FOUND;
                                done_next   = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                mode_next      = MODE_ANY;
                                scan_idx_next  = IW'(slot);
                                scan_left_next = CW'(1);
                            end
                        end
                        CMD_FIND_HEAP:
                        begin
                            mode_next = MODE_HEAP;
                        end
                        CMD_NEXT:
                        begin
                            if (used_count_reg == '0)
                            begin
                                status_next = ST_NONE_PEND;
                                done_next   = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                mode_next        = MODE_PEND;
                                last_served_next = last_clamp;
                                scan_idx_next    = rr_start;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous one is compared.
                if (scan_left_reg != '0)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg;
                    scan_idx_next  = idx_inc;
                    scan_left_next = scan_left_reg - CW'(1);
                end

                if (chk_valid_reg && match)
                begin
                    state_next       = S_IDLE;
                    done_next        = 1'b1;
                    status_next      = ST_OK;
                    hit_slot_next    = 4'(chk_idx_reg);
                    hit_port_next    = rd_entry.port;
                    hit_profile_next = rd_entry.profile;
                    hit_heap_next    = rd_entry.heap;
                    hit_virtual_next = rd_entry.is_virtual;
                    unique case (cmd_q_reg)
                        CMD_CREATE:
                        begin
                            status_next      = ST_PORT_USED;
                            hit_slot_next    = '0;
                            hit_port_next    = '0;
                            hit_profile_next = '0;
                            hit_heap_next    = '0;
                            hit_virtual_next = 1'b0;
                        end
                        CMD_REMOVE:
                        begin
                            // Shift the later entries down before reporting.
                            done_next      = 1'b0;
                            state_next     = S_SHIFT;
                            chk_valid_next = 1'b0;
                            scan_idx_next  = chk_idx_reg + IW'(1);
                            scan_left_next = used_count_reg - CW'(chk_idx_reg) - CW'(1);
                        end
                        CMD_MARK:
                        begin
                            if (rd_entry.is_virtual)
                            begin
                                wr_en            = 1'b1;
                                wr_entry.pending = 1'b1;
                            end
                            else
                            begin
                                call_native_next = 1'b1;
                            end
                        end
                        CMD_NEXT:
                        begin
                            wr_en            = 1'b1;
                            wr_entry.pending = 1'b0;
                            last_served_next = chk_idx_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (scan_left_reg == '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    unique case (cmd_q_reg)
                        CMD_CREATE:
                        begin
                            if (!found_q_reg)
                            begin
                                status_next = ST_NO_PROFILE;
                            end
                            else if (virt_q_reg && (heap_q_reg == '0))
                            begin
                                status_next = ST_NEEDS_INST;
                            end
                            else
                            begin
                                // Append the new entry after the last live slot.
                                wr_en               = 1'b1;
                                wr_addr             = IW'(used_count_reg);
                                wr_entry.port       = port_q_reg;
                                wr_entry.profile    = prof_q_reg;
                                wr_entry.heap       = heap_q_reg;
                                wr_entry.is_virtual = virt_q_reg;
                                wr_entry.pending    = virt_q_reg;
                                status_next         = ST_OK;
                                hit_slot_next       = 4'(used_count_reg);
                                hit_port_next       = port_q_reg;
                                hit_profile_next    = prof_q_reg;
                                hit_heap_next       = heap_q_reg;
                                hit_virtual_next    = virt_q_reg;
                                call_native_next    = !virt_q_reg;
                                used_count_next     = used_count_reg + CW'(1);
                            end
                        end
                        CMD_NEXT:
                        begin
                            status_next = ST_NONE_PEND;
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                if (scan_left_reg != '0)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg;
                    scan_idx_next  = idx_inc;
                    scan_left_next = scan_left_reg - CW'(1);
                end

                // Each entry read is written back one slot lower.
                if (chk_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_idx_reg - IW'(1);
                end
                else if (scan_left_reg == '0)
                begin
                    used_count_next = used_count_reg - CW'(1);
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chk_valid_reg   <= 1'b0;
            used_count_reg  <= '0;
            last_served_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chk_valid_reg   <= chk_valid_next;
            used_count_reg  <= used_count_next;
            last_served_reg <= last_served_next;
            done_reg        <= done_next;
        end
    end

    // Operands, scan pointers and result beat.
    always_ff @(posedge clk)
    begin
        cmd_q_reg       <= cmd_q_next;
        port_q_reg      <= port_q_next;
        prof_q_reg      <= prof_q_next;
        heap_q_reg      <= heap_q_next;
        found_q_reg     <= found_q_next;
        virt_q_reg      <= virt_q_next;
        mode_reg        <= mode_next;
        scan_idx_reg    <= scan_idx_next;
        scan_left_reg   <= scan_left_next;
        chk_idx_reg     <= chk_idx_next;
        status_reg      <= status_next;
        hit_slot_reg    <= hit_slot_next;
        hit_port_reg    <= hit_port_next;
        hit_profile_reg <= hit_profile_next;
        hit_heap_reg    <= hit_heap_next;
        hit_virtual_reg <= hit_virtual_next;
        call_native_reg <= call_native_next;
    end

    assign busy               = (state_reg != S_IDLE);
    assign done               = done_reg;
    assign status             = status_reg;
    assign hit_slot           = hit_slot_reg;
    assign hit_port           = hit_port_reg;
    assign hit_profile        = hit_profile_reg;
    assign hit_heap           = hit_heap_reg;
    assign hit_virtual        = hit_virtual_reg;
    assign call_native_update = call_native_reg;
    assign entry_total        = 4'(used_count_reg);

`ifndef SYNTHESIS
    // The entry count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(used_count_reg) <= CMPW'(MAX_ENDPOINTS))
        else $error("entry count above table size");

    // A result beat is only shown once the sequencer is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while busy");

    // Memory writes stay inside the live part of the table or its next slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CMPW'(wr_addr) <= CMPW'(used_count_reg))
                  && (CMPW'(wr_addr) < CMPW'(MAX_ENDPOINTS)))
        else $error("memory write out of range");

    // Create on a full table reports full in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_CREATE)
         && (used_count_reg == CW'(MAX_ENDPOINTS)))
        |=> (done_reg && (status_reg == ST_FULL)))
        else $error("full create not rejected");

    // A native update request only comes with a successful result.
    assert property (@(posedge clk) disable iff (!rst_n)
        call_native_reg |-> (done_reg && (status_reg == ST_OK)))
        else $error("native update without ok result");
`endif

endmodule

// File: tb/sv/endpoint_table_checker.sv
module endpoint_table_checker
    import etrr_pkg::*;
#(
    parameter int MAX_ENDPOINTS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  port,
    input  logic [15:0] profile_key,
    input  logic [7:0]  heap_id,
    input  logic [3:0]  slot,
    input  logic        profile_found,
    input  logic        profile_virtual,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [3:0]  hit_slot,
    input  logic [7:0]  hit_port,
    input  logic [15:0] hit_profile,
    input  logic [7:0]  hit_heap,
    input  logic        hit_virtual,
    input  logic        call_native_update,
    input  logic [3:0]  entry_total,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [7:0]  port;
        logic [15:0] profile;
        logic [7:0]  heap;
        logic        is_virtual;
        logic        native_call;
        logic [3:0]  total;
    } reply_t;

    // Shadow of the endpoint table and the round-robin pointer.
    entry_t      shadow_table [MAX_ENDPOINTS];
    int unsigned fill;
    int unsigned last_pick;

    // Replies owed by the block, oldest first.
    reply_t      owed_replies [$];

    function automatic int port_slot(input logic [7:0] p);
        for (int i = 0; i < fill; i++)
        begin
            if (shadow_table[i].port == p)
                return i;
        end
        return -1;
    endfunction

    // Reply carrying the contents of one live entry; the other fields are zero.
    function automatic reply_t entry_reply(input int unsigned idx);
        reply_t r;
        r = '0;
        r.slot = 4'(idx);
        r.port = shadow_table[idx].port;
        r.profile = shadow_table[idx].profile;
        r.heap = shadow_table[idx].heap;
        r.is_virtual = shadow_table[idx].is_virtual;
        return r;
    endfunction

    // Apply one command beat to the shadow table and return the reply it earns.
    function automatic reply_t apply_command(
        input logic [2:0]  c,
        input logic [7:0]  p,
        input logic [15:0] prof,
        input logic [7:0]  h,
        input logic [3:0]  s,
        input logic        found,
        input logic        virt
    );
        reply_t      r;
        logic [2:0]  st;
        int          k;
        int unsigned idx;
        int unsigned origin;

        r = '0;
        st = ST_OK;
        case (c)
            CMD_CREATE:
            begin
                if (fill >= MAX_ENDPOINTS)
                    st = ST_FULL;
                else if (port_slot(p) >= 0)
                    st = ST_PORT_USED;
                else if (!found)
                    st = ST_NO_PROFILE;
                else if (virt && h == 8'd0)
                    st = ST_NEEDS_INST;
                else
                begin
                    shadow_table[fill] = '{port: p, profile: prof, heap: h,
                                           is_virtual: virt, pending: virt};
                    r = entry_reply(fill);
                    r.native_call = !virt;
                    fill++;
                end
            end
            CMD_REMOVE:
            begin
                k = port_slot(p);
                if (k < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    // Report the entry where it was, then close the gap.
                    r = entry_reply(k);
                    for (int i = k + 1; i < fill; i++)
                        shadow_table[i - 1] = shadow_table[i];
                    fill--;
                end
            end
            CMD_FIND_PORT:
            begin
                k = port_slot(p);
                if (k < 0)
                    st = ST_NOT_FOUND;
                else
                    r = entry_reply(k);
            end
            CMD_GET_INDEX:
            begin
                if (s >= fill)
                    st = ST_NOT_FOUND;
                else
                    r = entry_reply(s);
            end
            CMD_FIND_HEAP:
            begin
                st = ST_NOT_FOUND;
                for (int i = 0; i < fill; i++)
                begin
                    if (shadow_table[i].heap == h)
                    begin
                        r = entry_reply(i);
                        st = ST_OK;
                        break;
                    end
                end
            end
            CMD_MARK:
            begin
                k = port_slot(p);
                if (k < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    r = entry_reply(k);
                    if (shadow_table[k].is_virtual)
                        shadow_table[k].pending = 1'b1;
                    else
                        r.native_call = 1'b1;
                end
            end
            CMD_NEXT:
            begin
                st = ST_NONE_PEND;
                if (fill != 0)
                begin
                    // A pointer left beyond the table is pulled back first.
                    if (last_pick >= fill)
                        last_pick = fill - 1;
                    origin = last_pick;
                    // Search after the last one served, ending on it.
                    for (int step = 1; step <= fill; step++)
                    begin
                        idx = (origin + step) % fill;
                        if (shadow_table[idx].pending)
                        begin
                            last_pick = idx;
                            shadow_table[idx].pending = 1'b0;
                            r = entry_reply(idx);
                            st = ST_OK;
                            break;
                        end
                    end
                end
            end
            default:
            begin
                st = ST_NOT_FOUND;
            end
        endcase
        r.status = st;
        r.total = 4'(fill);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fail_count++;
        end
    endtask

    // Compare each result beat with the oldest owed reply, then log new commands.
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            fill = 0;
            last_pick = 0;
            fail_count = 0;
            owed_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("hit_slot", 16'(want.slot), 16'(hit_slot));
                    check_field("hit_port", 16'(want.port), 16'(hit_port));
                    check_field("hit_profile", want.profile, hit_profile);
                    check_field("hit_heap", 16'(want.heap), 16'(hit_heap));
                    check_field("hit_virtual", 16'(want.is_virtual), 16'(hit_virtual));
                    check_field("call_native_update", 16'(want.native_call),
                                16'(call_native_update));
                    check_field("entry_total", 16'(want.total), 16'(entry_total));
                end
            end
            if (start && !busy)
                owed_replies.push_back(apply_command(cmd, port, profile_key, heap_id,
                                                     slot, profile_found,
                                                     profile_virtual));
            outstanding = owed_replies.size();
        end
    end

endmodule

// File: tb/sv/tb_endpoint_table_round_robin.sv
module tb_endpoint_table_round_robin
    import etrr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The one command code the block does not define.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int BEATS_PER_PHASE = 460;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start = 1'b0;
    logic [2:0]  cmd = CMD_CREATE;
    logic [7:0]  port = '0;
    logic [15:0] profile_key = '0;
    logic [7:0]  heap_id = '0;
    logic [3:0]  slot = '0;
    logic        profile_found = 1'b0;
    logic        profile_virtual = 1'b0;

    logic        busy;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  hit_slot;
    logic [7:0]  hit_port;
    logic [15:0] hit_profile;
    logic [7:0]  hit_heap;
    logic        hit_virtual;
    logic        call_native_update;
    logic [3:0]  entry_total;

    int          fail_count;
    int          outstanding;

    endpoint_table_round_robin dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .port               (port),
        .profile_key        (profile_key),
        .heap_id            (heap_id),
        .slot               (slot),
        .profile_found      (profile_found),
        .profile_virtual    (profile_virtual),
        .done               (done),
        .status             (status),
        .hit_slot           (hit_slot),
        .hit_port           (hit_port),
        .hit_profile        (hit_profile),
        .hit_heap           (hit_heap),
        .hit_virtual        (hit_virtual),
        .call_native_update (call_native_update),
        .entry_total        (entry_total)
    );

    endpoint_table_checker table_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .port               (port),
        .profile_key        (profile_key),
        .heap_id            (heap_id),
        .slot               (slot),
        .profile_found      (profile_found),
        .profile_virtual    (profile_virtual),
        .done               (done),
        .status             (status),
        .hit_slot           (hit_slot),
        .hit_port           (hit_port),
        .hit_profile        (hit_profile),
        .hit_heap           (hit_heap),
        .hit_virtual        (hit_virtual),
        .call_native_update (call_native_update),
        .entry_total        (entry_total),
        .fail_count         (fail_count),
        .outstanding        (outstanding)
    );

    always #2 clk = ~clk;

    // Drive one command beat and hold it until the block takes it.
    task automatic issue(input logic [2:0] c, input logic [7:0] p,
                         input logic [15:0] prof, input logic [7:0] h,
                         input logic [3:0] s, input logic found, input logic virt);
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        port <= p;
        profile_key <= prof;
        heap_id <= h;
        slot <= s;
        profile_found <= found;
        profile_virtual <= virt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Random gap before a beat; each extra idle cycle has the given chance.
    task automatic hold_off(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // A small set of ports, so that creates collide and lookups hit often.
    function automatic logic [7:0] pool_port(input int idx);
        case (idx)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd2;
            4:       return 8'd3;
            5:       return 8'd4;
            6:       return 8'd5;
            7:       return 8'd6;
            8:       return 8'd128;
            9:       return 8'd127;
            10:      return 8'd64;
            default: return 8'd200;
        endcase
    endfunction

    // One random beat; grow favors creates, otherwise removes outnumber creates.
    task automatic random_beat(input bit grow);
        int unsigned roll;
        int unsigned create_cut;
        int unsigned remove_cut;
        logic [2:0]  c;
        logic [7:0]  p;
        logic [7:0]  h;
        logic [3:0]  s;

        create_cut = grow ? 40 : 18;
        remove_cut = create_cut + (grow ? 12 : 26);
        roll = $urandom_range(0, 99);
        if (roll < create_cut)
            c = CMD_CREATE;
        else if (roll < remove_cut)
            c = CMD_REMOVE;
        else
        begin
            roll = $urandom_range(0, 40);
            if (roll < 8)
                c = CMD_FIND_PORT;
            else if (roll < 16)
                c = CMD_GET_INDEX;
            else if (roll < 24)
                c = CMD_FIND_HEAP;
            else if (roll < 32)
                c = CMD_MARK;
            else if (roll < 40)
                c = CMD_NEXT;
            else
                c = CMD_UNUSED;
        end

        if ($urandom_range(0, 4) == 0)
            p = 8'($urandom);
        else
            p = pool_port($urandom_range(0, 11));

        roll = $urandom_range(0, 9);
        if (roll < 3)
            h = 8'd0;
        else if (roll < 7)
            h = 8'($urandom_range(1, 5));
        else
            h = 8'($urandom);

        if ($urandom_range(0, 3) == 0)
            s = 4'($urandom);
        else
            s = 4'($urandom_range(0, 10));

        issue(c, p, 16'($urandom), h, s, $urandom_range(0, 9) != 0,
              1'($urandom_range(0, 1)));
    endtask

    // Give up if the run hangs.
    initial
    begin
        #2_000_000;
        $display("endpoint_table_round_robin: mismatch");
        $finish;
    end

    initial
    begin
        int idle_pct [3];
        bit grow;

        idle_pct = '{0, 85, 16};
        grow = 1'b1;
        rst_n = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: every lookup misses, nothing is pending.
        issue(CMD_NEXT, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_REMOVE, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_GET_INDEX, 8'd0, 16'd0, 8'd0, 4'd15, 1'b0, 1'b0);
        issue(CMD_FIND_HEAP, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 4'hF, 1'b1, 1'b1);

        // Create rejections, one native and one virtual entry, then a used port.
        issue(CMD_CREATE, 8'd7, 16'h1234, 8'd3, 4'd0, 1'b0, 1'b0);
        issue(CMD_CREATE, 8'd7, 16'h1234, 8'd0, 4'd0, 1'b1, 1'b1);
        issue(CMD_CREATE, 8'd0, 16'h0000, 8'd0, 4'd0, 1'b1, 1'b0);
        issue(CMD_CREATE, 8'd255, 16'hFFFF, 8'hFF, 4'd0, 1'b1, 1'b1);
        issue(CMD_CREATE, 8'd0, 16'h5555, 8'd9, 4'd0, 1'b1, 1'b0);

        // Heap id zero matches the native entry; marking and round-robin picks.
        issue(CMD_FIND_HEAP, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_FIND_PORT, 8'd255, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_MARK, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_NEXT, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_NEXT, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_MARK, 8'd255, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);

        // Fill the table, then create on a used port while full.
        for (int i = 0; i < 8; i++)
            issue(CMD_CREATE, 8'(16 + i), 16'($urandom), 8'(i + 1), 4'd0, 1'b1,
                  1'(i % 2));
        issue(CMD_CREATE, 8'd0, 16'hAAAA, 8'd1, 4'd0, 1'b1, 1'b1);
        issue(CMD_GET_INDEX, 8'd0, 16'd0, 8'd0, 4'd9, 1'b0, 1'b0);
        issue(CMD_REMOVE, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        issue(CMD_NEXT, 8'd0, 16'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        drain();

        // Random traffic in phases of sender idling, drifting between
        // a filling and an emptying table.
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    grow = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 149) == 0)
                    drain();
                hold_off(idle_pct[phase]);
                random_beat(grow);
            end
            drain();
        end

        // Let any late beat show up before the verdict.
        repeat (40)
            @(posedge clk);
        if (fail_count == 0)
            $display("endpoint_table_round_robin: match");
        else
            $display("endpoint_table_round_robin: mismatch");
        $finish;
    end

endmodule
